/* sv/nalsp_pkg.sv */
// nalsp_pkg: shared constants, result types and header decode for the nal unit splitter
// no dependencies
`default_nettype none

package nalsp_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int COUNT_BITS  = LENGTH_BITS + 1;
    localparam int LANES       = 4;
    localparam int LANE_BITS   = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_BITS    = 3;
    localparam int FILL_BITS   = 4;

    localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
    localparam logic [7:0] H265_TYPE_MASK = 8'h7E;
    localparam logic [5:0] H264_IDR       = 6'd5;
    localparam logic [5:0] H264_SPS       = 6'd7;
    localparam logic [5:0] H264_PPS       = 6'd8;
    localparam logic [5:0] H265_IRAP      = 6'd19;
    localparam logic [7:0] TAG_KEY        = 8'h17;
    localparam logic [7:0] TAG_INTER      = 8'h27;
    localparam logic [2:0] SC_SHORT       = 3'd3;
    localparam logic [2:0] SC_LONG        = 3'd4;
    localparam logic       MODE_H264      = 1'b0;
    localparam logic       MODE_H265      = 1'b1;

    typedef struct packed {
        logic [7:0]             payload_byte;
        logic                   unit_first;
        logic                   unit_last;
        logic [5:0]             unit_type;
        logic                   key_frame;
        logic                   parameter_set;
        logic [2:0]             start_code_length;
        logic [LENGTH_BITS-1:0] unit_length;
        logic                   length_saturated;
        logic [7:0]             tag_frame_byte;
    } t_result;

    typedef struct packed {
        logic [LANE_BITS-1:0]  count;
        t_result [LANES-1:0]   lane;
    } t_push;

    function automatic logic [5:0] nal_type(input logic [7:0] hdr, input logic mode);
        logic [7:0] m;
        if (mode == MODE_H265) begin
            m = (hdr & H265_TYPE_MASK) >> 1;
        end else begin
            m = hdr & H264_TYPE_MASK;
        end
        return m[5:0];
    endfunction

    function automatic logic nal_key(input logic [5:0] typ, input logic mode);
        return (mode == MODE_H265) ? (typ == H265_IRAP) : (typ == H264_IDR);
    endfunction

endpackage

`default_nettype wire

/* sv/nalsp_parse.sv */
// nalsp_parse: input word register, start code window and per-word result lanes
// depends on nalsp_pkg
`default_nettype none

module nalsp_parse
    import nalsp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_valid,
    input  wire logic   i_cfg_codec_mode,
    input  wire logic   i_valid,
    input  wire logic   [7:0] i_stream_byte,
    input  wire logic   i_end_of_stream,
    output logic        o_ready,
    input  wire logic   i_room,
    output t_push       o_push
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eos;
    logic                  r_codec_mode;

    logic [7:0]            r_win [4];
    logic [2:0]            r_wcnt;
    logic                  r_inside;
    logic                  r_hdr_pend;
    logic [5:0]            r_type;
    logic                  r_key;
    logic [2:0]            r_sc_len;
    logic [COUNT_BITS-1:0] r_count;

    logic [7:0]            n_win [4];
    logic [2:0]            n_wcnt;
    logic                  n_inside;
    logic                  n_hdr_pend;
    logic [5:0]            n_type;
    logic                  n_key;
    logic [2:0]            n_sc_len;
    logic [COUNT_BITS-1:0] n_count;

    logic                  commit;

    assign commit  = r_in_valid & i_room;
    assign o_ready = ~r_in_valid | i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_stream_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= MODE_H264;
        end else if (i_cfg_valid) begin
            r_codec_mode <= i_cfg_codec_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_win[i] <= 8'd0;
            end
            r_wcnt     <= 3'd0;
            r_inside   <= 1'b0;
            r_hdr_pend <= 1'b0;
            r_type     <= 6'd0;
            r_key      <= 1'b0;
            r_sc_len   <= 3'd0;
            r_count    <= '0;
        end else if (commit) begin
            r_win      <= n_win;
            r_wcnt     <= n_wcnt;
            r_inside   <= n_inside;
            r_hdr_pend <= n_hdr_pend;
            r_type     <= n_type;
            r_key      <= n_key;
            r_sc_len   <= n_sc_len;
            r_count    <= n_count;
        end
    end

    always_comb begin : p_parse
        logic [2:0]            im1;
        logic [2:0]            im2;
        logic [2:0]            im3;
        logic                  sc3;
        logic                  sc4;
        logic [7:0]            stage_b [5];
        logic [2:0]            ncnt;
        logic [2:0]            zeros;
        logic [2:0]            hold;
        logic [2:0]            drop;
        logic [2:0]            idx;
        logic [2:0]            keep;
        logic [2:0]            n_emit;
        logic [2:0]            last_idx;
        logic                  run;
        logic                  has_last;
        logic [7:0]            eb [LANES];
        logic                  hdr_now;
        logic [5:0]            ltype;
        logic                  lkey;
        logic                  lpset;
        logic                  llast;
        logic [COUNT_BITS-1:0] sum;
        logic [COUNT_BITS-1:0] lane_cnt [LANES];

        im1 = r_wcnt - 3'd1;
        im2 = r_wcnt - 3'd2;
        im3 = r_wcnt - 3'd3;
        sc3 = (r_in_byte == 8'd1) && (r_wcnt >= 3'd2)
              && (r_win[im1[1:0]] == 8'd0) && (r_win[im2[1:0]] == 8'd0);
        sc4 = sc3 && (r_wcnt >= 3'd3) && (r_win[im3[1:0]] == 8'd0);

        for (int i = 0; i < 4; i++) begin
            stage_b[i] = r_win[i];
        end
        stage_b[4]      = 8'd0;
        stage_b[r_wcnt] = r_in_byte;
        ncnt            = r_wcnt + 3'd1;

        // trailing zero run decides how much stays held
        zeros = 3'd0;
        run   = 1'b1;
        for (int i = 0; i < 3; i++) begin
            idx = (3'(i) < ncnt) ? (ncnt - 3'd1 - 3'(i)) : 3'd0;
            if (run && (3'(i) < ncnt) && (stage_b[idx] == 8'd0)) begin
                zeros = zeros + 3'd1;
            end else begin
                run = 1'b0;
            end
        end
        hold = ((zeros + 3'd1) < ncnt) ? (zeros + 3'd1) : ncnt;
        drop = ncnt - hold;
        keep = sc4 ? (r_wcnt - 3'd3) : (r_wcnt - 3'd2);

        for (int k = 0; k < LANES; k++) begin
            eb[k] = stage_b[k];
        end
        if (sc3) begin
            for (int k = 0; k < LANES; k++) begin
                eb[k] = r_win[k];
            end
            n_emit   = keep;
            has_last = 1'b1;
        end else if (r_in_eos) begin
            has_last = 1'b1;
            if (ncnt == 3'd5) begin
                for (int k = 1; k < LANES; k++) begin
                    eb[k] = stage_b[k+1];
                end
                n_emit = 3'd4;
            end else begin
                n_emit = ncnt;
            end
        end else begin
            n_emit   = drop;
            has_last = 1'b0;
        end
        if (!r_inside) begin
            n_emit = 3'd0;
        end

        hdr_now = r_hdr_pend && (n_emit != 3'd0);
        ltype   = hdr_now ? nal_type(eb[0], r_codec_mode) : r_type;
        lkey    = hdr_now ? nal_key(ltype, r_codec_mode) : r_key;
        lpset   = (r_codec_mode == MODE_H264) && ((ltype == H264_SPS) || (ltype == H264_PPS));

        for (int k = 0; k < LANES; k++) begin
            sum         = r_count + COUNT_BITS'(k + 1);
            lane_cnt[k] = sum[LENGTH_BITS] ? {1'b1, {LENGTH_BITS{1'b0}}} : sum;
            llast       = has_last && (3'(k + 1) == n_emit);
            o_push.lane[k].payload_byte      = eb[k];
            o_push.lane[k].unit_first        = (k == 0) && hdr_now;
            o_push.lane[k].unit_last         = llast;
            o_push.lane[k].unit_type         = ltype;
            o_push.lane[k].key_frame         = lkey;
            o_push.lane[k].parameter_set     = lpset;
            o_push.lane[k].start_code_length = r_sc_len;
            o_push.lane[k].length_saturated  = llast && lane_cnt[k][LENGTH_BITS];
            o_push.lane[k].tag_frame_byte    = lkey ? TAG_KEY : TAG_INTER;
            if (!llast) begin
                o_push.lane[k].unit_length = '0;
            end else if (lane_cnt[k][LENGTH_BITS]) begin
                o_push.lane[k].unit_length = {LENGTH_BITS{1'b1}};
            end else begin
                o_push.lane[k].unit_length = lane_cnt[k][LENGTH_BITS-1:0];
            end
        end
        o_push.count = commit ? n_emit : 3'd0;

        last_idx   = n_emit - 3'd1;
        n_type     = ltype;
        n_key      = lkey;
        n_hdr_pend = r_hdr_pend && !hdr_now;
        n_count    = (n_emit != 3'd0) ? lane_cnt[last_idx[1:0]] : r_count;
        n_inside   = r_inside;
        n_sc_len   = r_sc_len;
        for (int i = 0; i < 4; i++) begin
            idx      = (3'(i) < hold) ? (drop + 3'(i)) : 3'd0;
            n_win[i] = (3'(i) < hold) ? stage_b[idx] : 8'd0;
        end
        n_wcnt = hold;

        if (sc3) begin
            for (int i = 0; i < 4; i++) begin
                n_win[i] = 8'd0;
            end
            n_wcnt     = 3'd0;
            n_inside   = 1'b1;
            n_hdr_pend = 1'b1;
            n_sc_len   = sc4 ? SC_LONG : SC_SHORT;
            n_count    = '0;
        end
        if (r_in_eos) begin
            for (int i = 0; i < 4; i++) begin
                n_win[i] = 8'd0;
            end
            n_wcnt     = 3'd0;
            n_inside   = 1'b0;
            n_hdr_pend = 1'b0;
            n_type     = 6'd0;
            n_key      = 1'b0;
            n_sc_len   = 3'd0;
            n_count    = '0;
        end
    end

endmodule

`default_nettype wire

/* sv/nalsp_fifo.sv */
// nalsp_fifo: result queue taking up to four words per cycle and giving one while i_ready is high
// depends on nalsp_pkg
`default_nettype none

module nalsp_fifo
    import nalsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_head
);

    t_result              r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]  r_wr;
    logic [PTR_BITS-1:0]  r_rd;
    logic [FILL_BITS-1:0] r_fill;
    logic                 pop;

    assign o_valid = (r_fill != '0);
    assign pop     = o_valid & i_ready;
    assign o_room  = (r_fill <= FILL_BITS'(FIFO_DEPTH - LANES));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            if (LANE_BITS'(k) < i_push.count) begin
                r_mem[r_wr + PTR_BITS'(k)] <= i_push.lane[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= r_wr + PTR_BITS'(i_push.count);
            r_rd   <= r_rd + PTR_BITS'(pop);
            r_fill <= r_fill + FILL_BITS'(i_push.count) - FILL_BITS'(pop);
        end
    end

endmodule

`default_nettype wire

/* sv/annexb_nal_unit_splitter_core.sv */
// a word is held in the input register until it commits, then its results enter the queue;
// words that may belong to a start code wait until a later word settles them
// throughput: one stream word per cycle; one word yields up to four results, delivered one
// per cycle while i_ready is high from an eight-entry queue; input stalls above four entries
// reset: synchronous active low, clears window, unit state and queue, codec_mode to H.264
// annexb_nal_unit_splitter_core: top level, depends on nalsp_pkg, nalsp_parse, nalsp_fifo
`default_nettype none

module annexb_nal_unit_splitter_core
    import nalsp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic                   i_cfg_codec_mode,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [7:0]             i_stream_byte,
    input  wire logic                   i_end_of_stream,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [7:0]                  o_payload_byte,
    output logic                        o_unit_first,
    output logic                        o_unit_last,
    output logic [5:0]                  o_unit_type,
    output logic                        o_key_frame,
    output logic                        o_parameter_set,
    output logic [2:0]                  o_start_code_length,
    output logic [LENGTH_BITS-1:0]      o_unit_length,
    output logic                        o_length_saturated,
    output logic [7:0]                  o_tag_frame_byte
);

    t_push   push;
    t_result head;
    logic    room;

    assign o_cfg_ready = 1'b1;

    nalsp_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_codec_mode (i_cfg_codec_mode),
        .i_valid          (i_valid),
        .i_stream_byte    (i_stream_byte),
        .i_end_of_stream  (i_end_of_stream),
        .o_ready          (o_ready),
        .i_room           (room),
        .o_push           (push)
    );

    nalsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_payload_byte      = head.payload_byte;
    assign o_unit_first        = head.unit_first;
    assign o_unit_last         = head.unit_last;
    assign o_unit_type         = head.unit_type;
    assign o_key_frame         = head.key_frame;
    assign o_parameter_set     = head.parameter_set;
    assign o_start_code_length = head.start_code_length;
    assign o_unit_length       = head.unit_length;
    assign o_length_saturated  = head.length_saturated;
    assign o_tag_frame_byte    = head.tag_frame_byte;

endmodule

`default_nettype wire

/* sv/nalsp_checker.sv */
// nalsp_checker: port-level assertions on the splitter core, bound to the top level
// depends on nalsp_pkg and annexb_nal_unit_splitter_core
`default_nettype none

module nalsp_checker
    import nalsp_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic [7:0]             o_payload_byte,
    input wire logic                   o_unit_first,
    input wire logic                   o_unit_last,
    input wire logic [5:0]             o_unit_type,
    input wire logic                   o_key_frame,
    input wire logic                   o_parameter_set,
    input wire logic [2:0]             o_start_code_length,
    input wire logic [LENGTH_BITS-1:0] o_unit_length,
    input wire logic                   o_length_saturated,
    input wire logic [7:0]             o_tag_frame_byte
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_payload_byte) && $stable(o_unit_first)
            && $stable(o_unit_last) && $stable(o_unit_type) && $stable(o_key_frame)
            && $stable(o_parameter_set) && $stable(o_start_code_length)
            && $stable(o_unit_length) && $stable(o_length_saturated)
            && $stable(o_tag_frame_byte))
        else $error("output word changed while stalled");

    a_len_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_unit_last |-> (o_unit_length == '0) && !o_length_saturated)
        else $error("length shown on a word that is not last");

    a_tag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_frame && o_tag_frame_byte == TAG_KEY)
                 || (!o_key_frame && o_tag_frame_byte == TAG_INTER))
        else $error("tag byte disagrees with key flag");

    a_sc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_start_code_length == SC_SHORT) || (o_start_code_length == SC_LONG))
        else $error("bad start code length");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind annexb_nal_unit_splitter_core nalsp_checker u_nalsp_checker (.*);

`default_nettype wire

/* tb/annexb_nal_unit_splitter_core_test.sv */
// annexb_nal_unit_splitter_core_test: self-checking bench for the annex b nal unit splitter
// drives byte streams and codec mode writes, predicts every payload word and checks it
// depends on nalsp_pkg and annexb_nal_unit_splitter_core
`timescale 1ns / 1ps

module annexb_nal_unit_splitter_core_test;
    import nalsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [COUNT_BITS-1:0] LEN_MAX = {1'b0, {LENGTH_BITS{1'b1}}};

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_stream_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_codec_mode = MODE_H264;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [7:0]             i_stream_byte = 8'h00;
    logic                   i_end_of_stream = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [7:0]             o_payload_byte;
    logic                   o_unit_first;
    logic                   o_unit_last;
    logic [5:0]             o_unit_type;
    logic                   o_key_frame;
    logic                   o_parameter_set;
    logic [2:0]             o_start_code_length;
    logic [LENGTH_BITS-1:0] o_unit_length;
    logic                   o_length_saturated;
    logic [7:0]             o_tag_frame_byte;

    annexb_nal_unit_splitter_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_codec_mode   (i_cfg_codec_mode),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_stream_byte      (i_stream_byte),
        .i_end_of_stream    (i_end_of_stream),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_payload_byte     (o_payload_byte),
        .o_unit_first       (o_unit_first),
        .o_unit_last        (o_unit_last),
        .o_unit_type        (o_unit_type),
        .o_key_frame        (o_key_frame),
        .o_parameter_set    (o_parameter_set),
        .o_start_code_length(o_start_code_length),
        .o_unit_length      (o_unit_length),
        .o_length_saturated (o_length_saturated),
        .o_tag_frame_byte   (o_tag_frame_byte)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // splitter state as seen by the checker
    logic                   codec_mode_now = MODE_H264;
    logic [7:0]             win [4];
    int                     win_n = 0;
    logic                   in_unit = 1'b0;
    logic                   hdr_pending = 1'b0;
    logic [5:0]             cur_type = '0;
    logic                   cur_key = 1'b0;
    logic [2:0]             cur_sc = '0;
    logic [COUNT_BITS-1:0]  unit_count = '0;

    t_stream_word words_to_send[$];
    t_result      pending_payload[$];

    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int units_closed = 0;
    int key_units = 0;
    int cycles = 0;

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void clear_unit();
        for (int i = 0; i < 4; i++) begin
            win[i] = 8'h00;
        end
        win_n = 0;
        in_unit = 1'b0;
        hdr_pending = 1'b0;
        cur_type = '0;
        cur_key = 1'b0;
        cur_sc = '0;
        unit_count = '0;
    endfunction

    function automatic void push_payload(logic [7:0] b, logic last);
        t_result r;
        if (!in_unit) begin
            return;
        end
        r = '0;
        if (hdr_pending) begin
            if (codec_mode_now == MODE_H264) begin
                cur_type = 6'(b & H264_TYPE_MASK);
                cur_key = (cur_type == H264_IDR);
            end else begin
                cur_type = 6'((b & H265_TYPE_MASK) >> 1);
                cur_key = (cur_type == H265_IRAP);
            end
            hdr_pending = 1'b0;
            r.unit_first = 1'b1;
        end
        if (unit_count <= LEN_MAX) begin
            unit_count++;
        end
        r.payload_byte = b;
        r.unit_last = last;
        r.unit_type = cur_type;
        r.key_frame = cur_key;
        r.parameter_set = (codec_mode_now == MODE_H264) &&
                          (cur_type == H264_SPS || cur_type == H264_PPS);
        r.start_code_length = cur_sc;
        if (last) begin
            r.length_saturated = (unit_count > LEN_MAX);
            r.unit_length = r.length_saturated ? LEN_MAX[LENGTH_BITS-1:0]
                                               : unit_count[LENGTH_BITS-1:0];
        end
        r.tag_frame_byte = cur_key ? TAG_KEY : TAG_INTER;
        pending_payload.push_back(r);
    endfunction

    // one accepted stream word: strip start codes, hold possible start code bytes
    function automatic void split_stream_word(logic [7:0] b, logic eos);
        logic [7:0] held [5];
        int n;
        int sc;
        int keep;
        int zeros;
        int hold;
        int drop;
        int first_i;
        n = win_n;
        sc = 0;
        if (b == 8'h01 && n >= 2) begin
            if (win[n-1] == 8'h00 && win[n-2] == 8'h00) begin
                sc = int'(SC_SHORT);
                if (n >= 3) begin
                    if (win[n-3] == 8'h00) sc = int'(SC_LONG);
                end
            end
        end
        if (sc != 0) begin
            keep = n - (sc - 1);
            for (int i = 0; i < keep; i++) begin
                push_payload(win[i], i == keep - 1);
            end
            win_n = 0;
            in_unit = 1'b1;
            hdr_pending = 1'b1;
            cur_sc = 3'(sc);
            unit_count = '0;
            if (eos) clear_unit();
            return;
        end
        for (int i = 0; i < n; i++) begin
            held[i] = win[i];
        end
        held[n] = b;
        n++;
        if (eos) begin
            first_i = 0;
            // five bytes to flush: one zero of the run is dropped
            if (n == 5) begin
                held[1] = held[0];
                first_i = 1;
            end
            for (int i = first_i; i < n; i++) begin
                push_payload(held[i], i == n - 1);
            end
            clear_unit();
            return;
        end
        zeros = 0;
        while (zeros < n && held[n-1-zeros] == 8'h00) zeros++;
        hold = zeros + 1;
        if (hold > 4) hold = 4;
        if (hold > n) hold = n;
        drop = n - hold;
        for (int i = 0; i < drop; i++) begin
            push_payload(held[i], 1'b0);
        end
        for (int i = 0; i < 4; i++) begin
            win[i] = (i < hold) ? held[drop + i] : 8'h00;
        end
        win_n = hold;
    endfunction

    // stream driver
    always @(posedge i_clk) begin
        t_stream_word w;
        logic gap;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                split_stream_word(i_stream_byte, i_end_of_stream);
                words_sent++;
            end
            if (!i_valid || o_ready) begin
                gap = ($urandom_range(0, 99) < 8) && !(words_sent >= 150 && words_sent < 250);
                if (words_to_send.size() != 0 && !gap) begin
                    w = words_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_stream_byte <= w.data;
                    i_end_of_stream <= w.eos;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            note_error($sformatf("word %0d %s: expected %0h, got %0h",
                                 words_checked, name, want, got));
        end
    endtask

    // payload monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_payload.size() == 0) begin
                note_error($sformatf("word %0d: payload %02h arrived with nothing expected",
                                     words_checked, o_payload_byte));
            end else begin
                want = pending_payload.pop_front();
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("unit_first", 32'(want.unit_first), 32'(o_unit_first));
                check_field("unit_last", 32'(want.unit_last), 32'(o_unit_last));
                check_field("unit_type", 32'(want.unit_type), 32'(o_unit_type));
                check_field("key_frame", 32'(want.key_frame), 32'(o_key_frame));
                check_field("parameter_set", 32'(want.parameter_set),
                            32'(o_parameter_set));
                check_field("start_code_length", 32'(want.start_code_length),
                            32'(o_start_code_length));
                check_field("unit_length", 32'(want.unit_length), 32'(o_unit_length));
                check_field("length_saturated", 32'(want.length_saturated),
                            32'(o_length_saturated));
                check_field("tag_frame_byte", 32'(want.tag_frame_byte),
                            32'(o_tag_frame_byte));
                if (want.unit_last) begin
                    units_closed++;
                    if (want.key_frame) key_units++;
                end
            end
            words_checked++;
        end
        i_ready <= ($urandom_range(0, 99) >= 8) || (words_checked >= 200 && words_checked < 320);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_word(logic [7:0] b, logic eos);
        t_stream_word w;
        w.data = b;
        w.eos = eos;
        words_to_send.push_back(w);
    endtask

    function automatic logic [7:0] any_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] any_header();
        case ($urandom_range(0, 7))
            0: return 8'h65;
            1: return 8'h67;
            2: return 8'h68;
            3: return 8'h41;
            4: return 8'h26;
            5: return 8'h40;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_start_code();
        if ($urandom_range(0, 1)) add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h01, 1'b0);
    endtask

    task automatic add_stream();
        int len;
        int units;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(4, 20);
            for (int i = 0; i < len; i++) begin
                add_word(any_byte(), i == len - 1);
            end
            return;
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) add_word(any_byte(), 1'b0);
        end
        units = $urandom_range(1, 4);
        repeat (units) begin
            add_start_code();
            if ($urandom_range(0, 9) != 0) begin
                add_word(any_header(), 1'b0);
                repeat ($urandom_range(0, 10)) add_word(any_byte(), 1'b0);
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            add_word(8'h00, 1'b0);
            add_word(8'h00, 1'b0);
            add_word(8'h01, 1'b1);
        end else begin
            add_word(any_byte(), 1'b1);
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (words_to_send.size() != 0 || i_valid || pending_payload.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_codec_mode(logic mode);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_codec_mode <= mode;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        codec_mode_now = mode;
    endtask

    initial begin
        logic phase_mode [6];
        int start_count;
        phase_mode = '{MODE_H265, MODE_H264, MODE_H264, MODE_H265, MODE_H264, MODE_H264};
        phase_mode[4] = 1'($urandom_range(0, 1));
        clear_unit();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: leading garbage, both start codes, idr, sps, empty unit, overfull flush
        add_word(8'hFF, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h01, 1'b0);
        add_word(8'h65, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h01, 1'b0);
        add_word(8'h67, 1'b0);
        add_word(8'h80, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h01, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h01, 1'b0);
        add_word(8'h68, 1'b0);
        repeat (4) add_word(8'h00, 1'b0);
        add_word(8'h55, 1'b1);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_codec_mode(phase_mode[p]);
            start_count = words_to_send.size();
            while (words_to_send.size() - start_count < 45) add_stream();
            // leave an sps open so the mode changes inside a unit
            if (p == 2) begin
                add_start_code();
                add_word(8'h67, 1'b0);
                add_word(8'h11, 1'b0);
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (pending_payload.size() != 0) begin
            note_error($sformatf("%0d expected payload words never arrived",
                                 pending_payload.size()));
        end
        $display("sent %0d stream words in both codec modes, checked %0d payload words",
                 words_sent, words_checked);
        $display("closed %0d units, %0d of them key frames, %0d mismatches",
                 units_closed, key_units, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
